// ----- sv/sazs_pkg.sv -----
// ----------------------------------------------------------------------------
// Sensor auto-zero supervisor package
// Widths, reset values, register indexes, word kinds and result codes shared
// by the supervisor.
// ----------------------------------------------------------------------------
package sazs_pkg;

  localparam int SAZS_SAMPLE_WIDTH = 16;
  localparam int SAZS_START_DELAY  = 3;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_AVERAGE_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_LIMIT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_MAX    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_MIN    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_DIFF      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_LAST_OFFSET   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_LOWER_TIMEOUT = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TIME   = 3'd7;

  // Register reset values
  localparam logic [7:0]         RST_AVERAGE_COUNT = 8'd20;
  localparam logic [15:0]        RST_RANGE_LIMIT   = 16'd32;
  localparam logic signed [15:0] RST_OFFSET_MAX    = 16'sd160;
  localparam logic signed [15:0] RST_OFFSET_MIN    = -16'sd160;
  localparam logic [15:0]        RST_MAX_DIFF      = 16'd80;
  localparam logic signed [15:0] RST_LAST_OFFSET   = 16'sd0;
  localparam logic [15:0]        RST_LOWER_TIMEOUT = 16'd150;
  localparam logic [15:0]        RST_SETTLE_TIME   = 16'd20;

  // Input word kinds
  localparam logic KIND_ENTER = 1'b0;
  localparam logic KIND_CYCLE = 1'b1;

  // Transition codes
  localparam logic [1:0] TRANS_NONE    = 2'd0;
  localparam logic [1:0] TRANS_LOWERED = 2'd1;
  localparam logic [1:0] TRANS_FAILURE = 2'd2;

  // Zero alarm codes
  localparam logic [1:0] ALARM_NONE  = 2'd0;
  localparam logic [1:0] ALARM_RANGE = 2'd1;
  localparam logic [1:0] ALARM_ABOVE = 2'd2;
  localparam logic [1:0] ALARM_BELOW = 2'd3;

  // Rounded offset limit in whole mmHg
  localparam logic [11:0] ROUNDED_MAX = 12'd2047;

  typedef struct packed {
    logic failure;
    logic timer_started;
    logic fully_lowered;
    logic lowered;
    logic too_long;
  } sazs_flags_t;

  // A timer loaded with zero is loaded with one instead.
  function automatic logic [15:0] load_len(input logic [15:0] n);
    return (n == 16'd0) ? 16'd1 : n;
  endfunction

endpackage

// ----- sv/sensor_auto_zero_supervisor.sv -----
// ----------------------------------------------------------------------------
// Sensor auto-zero supervisor
// Supervises the lowering of a mechanism and the auto-zero of a pressure
// sensor, one control cycle per input word, with a serial divider for the mean.
// ----------------------------------------------------------------------------
// Usage:
//  The input channel (s_*) carries one control cycle per word; s_tuser marks
//  an enter word (0) or a control cycle (1). Each accepted word gives exactly
//  one result word on the output channel (m_*). Configuration is written
//  through cfg_we/cfg_index/cfg_data; the user must do so only while the
//  block is idle; the block does not enforce this. A word that does not
//  complete a sample set goes from acceptance through the final step to
//  the result register. A word that completes a set runs the mean through
//  a set-up step, a restoring divider, one quotient bit per cycle, and a
//  check step. s_tready is high only while no word is in work.
//  When the receiver stalls, the finished result stays in the output
//  register; the next word is still taken and then waits in its last step
//  until the register is free.
//  Reset (rst, synchronous) loads the register defaults and clears all timers,
//  flags, counts and the sample sum; the block is ready in the next cycle.
// ----------------------------------------------------------------------------
module sensor_auto_zero_supervisor #(
  parameter int SAMPLE_WIDTH = sazs_pkg::SAZS_SAMPLE_WIDTH,
  parameter int START_DELAY  = sazs_pkg::SAZS_START_DELAY
) (
  input  logic                                clk,
  input  logic                                rst,
  // s_tdata: aps_sample[15:0], cassette_down[16], alarm_active[17], zero pad
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [23:0]                         s_tdata,
  // s_tuser: kind[0]
  input  logic [0:0]                          s_tuser,
  // m_tdata: transition[1:0], zero_alarm[3:2], lower_failed[4],
  // range_warning[5], zero_valid[6], zero_offset[22:7], zero_rounded[34:23],
  // lower_command[35], zero pad
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [39:0]                         m_tdata,
  input  logic                                cfg_we,
  input  logic [sazs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sazs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import sazs_pkg::*;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int TOTW = SW + 8;            // sum of up to 255 samples
  localparam int NUMW = TOTW + 1;          // 2*|sum| + count
  localparam int MW   = SW + 1;            // magnitude of the mean
  localparam int CNTW = $clog2(NUMW + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_CHECK,
    ST_FIN
  } state_t;

  state_t state;

  // Configuration registers
  logic [7:0]         average_count;
  logic [15:0]        range_limit;
  logic signed [15:0] offset_max;
  logic signed [15:0] offset_min;
  logic [15:0]        max_diff;
  logic signed [15:0] last_offset;
  logic [15:0]        lower_timeout;
  logic [15:0]        settle_time;

  // Supervisor state
  logic [1:0]           start_delay;
  logic [7:0]           sample_count;
  logic signed [TOTW-1:0] sample_total;
  logic signed [SW-1:0] sample_min;
  logic signed [SW-1:0] sample_max;
  logic                 zero_done;
  logic [1:0]           alarm_held;
  sazs_flags_t          flags;
  logic [15:0]          timeout_count;
  logic [15:0]          settle_count;

  // Word in work
  logic item_enter;
  logic item_down;
  logic item_alarm;
  logic res_cmd;
  logic res_warn;
  logic res_valid;
  logic signed [15:0] res_zoff;
  logic signed [11:0] res_zrnd;

  // Divider
  logic [NUMW-1:0] div_num;
  logic [8:0]      div_rem;
  logic [CNTW-1:0] div_cnt;
  logic            total_neg;

  // Output register
  logic [1:0]  out_trans;
  logic [1:0]  out_alarm;
  logic        out_lfail;
  logic        out_warn;
  logic        out_valid;
  logic [15:0] out_zoff;
  logic [11:0] out_zrnd;
  logic        out_cmd;

  assign s_tready = (state == ST_IDLE) && !rst;
  assign m_tdata  = {4'b0000, out_cmd, out_zrnd, out_zoff, out_valid, out_warn,
                     out_lfail, out_alarm, out_trans};

  // --------------------------------------------------------------------------
  // Acceptance step: timers, lower command and sampling
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] sample_in;
  sazs_flags_t          flags_acc;
  logic [15:0]          timeout_acc;
  logic [15:0]          settle_acc;
  logic                 lower_cmd;
  logic [1:0]           delay_acc;
  logic                 take_sample;
  logic [7:0]           count_acc;

  // Samples wider than the field see it zero-extended, as the field is read
  // only in its low bits.
  assign sample_in = $signed(SW'(s_tdata[15:0]));

  always_comb begin
    flags_acc   = flags;
    timeout_acc = timeout_count;
    settle_acc  = settle_count;
    lower_cmd   = 1'b0;
    if (timeout_count != 16'd0) begin
      timeout_acc = timeout_count - 16'd1;
      if (timeout_count == 16'd1) begin
        flags_acc.too_long = 1'b1;
      end
    end
    if (settle_count != 16'd0) begin
      settle_acc = settle_count - 16'd1;
      if (settle_count == 16'd1) begin
        flags_acc.fully_lowered = 1'b1;
      end
    end
    if (alarm_held == ALARM_NONE && !flags_acc.failure) begin
      lower_cmd = 1'b1;
      if (!flags_acc.timer_started) begin
        timeout_acc             = load_len(lower_timeout);
        flags_acc.timer_started = 1'b1;
      end
    end
    delay_acc   = (start_delay != 2'd0) ? start_delay - 2'd1 : start_delay;
    take_sample = (delay_acc == 2'd0) && (sample_count < average_count);
    count_acc   = sample_count + 8'd1;
  end

  // --------------------------------------------------------------------------
  // Divider step and its set-up
  // --------------------------------------------------------------------------
  logic [TOTW-1:0] total_mag;
  logic [8:0]      divisor;
  logic [9:0]      div_trial;
  logic            div_ge;
  logic [8:0]      div_rem_next;

  assign total_mag = sample_total[TOTW-1] ? $unsigned(-sample_total)
                                          : $unsigned(sample_total);
  assign divisor   = {sample_count, 1'b0};
  assign div_trial = {div_rem, div_num[NUMW-1]};
  assign div_ge    = (div_trial >= {1'b0, divisor});

  always_comb begin
    if (div_ge) begin
      div_rem_next = 9'(div_trial - {1'b0, divisor});
    end else begin
      div_rem_next = div_trial[8:0];
    end
  end

  // --------------------------------------------------------------------------
  // Checks on the finished mean
  // --------------------------------------------------------------------------
  logic [MW-1:0]       q_mag;
  logic signed [31:0]  mean_w;
  logic signed [15:0]  mean_sat;
  logic signed [16:0]  mean_ext;
  logic [16:0]         mean_mag;
  logic [16:0]         round_sum;
  logic [12:0]         round_q;
  logic signed [11:0]  mean_rnd;
  logic signed [SW:0]  spread;
  logic [31:0]         spread_w;
  logic signed [17:0]  win_hi;
  logic signed [17:0]  win_lo;
  logic [1:0]          alarm_chk;
  logic                warn_chk;

  assign q_mag = div_num[MW-1:0];

  always_comb begin
    mean_w = total_neg ? -$signed(32'(q_mag)) : $signed(32'(q_mag));
    if (mean_w > 32'sd32767) begin
      mean_sat = 16'sh7FFF;
    end else if (mean_w < -32'sd32768) begin
      mean_sat = 16'sh8000;
    end else begin
      mean_sat = mean_w[15:0];
    end

    // Whole mmHg, ties away from zero, positive side limited
    mean_ext  = 17'(mean_sat);
    mean_mag  = mean_ext[16] ? $unsigned(-mean_ext) : $unsigned(mean_ext);
    round_sum = mean_mag + 17'd8;
    round_q   = round_sum[16:4];
    if (mean_ext[16]) begin
      mean_rnd = $signed(12'(-round_q));
    end else if (round_q > 13'(ROUNDED_MAX)) begin
      mean_rnd = $signed(ROUNDED_MAX);
    end else begin
      mean_rnd = $signed(round_q[11:0]);
    end

    spread   = (SW+1)'(sample_max) - (SW+1)'(sample_min);
    spread_w = 32'($unsigned(spread));
    win_hi   = 18'(last_offset) + $signed({2'b00, max_diff});
    win_lo   = 18'(last_offset) - $signed({2'b00, max_diff});

    alarm_chk = alarm_held;
    warn_chk  = 1'b0;
    if (spread_w > 32'(range_limit)) begin
      alarm_chk = ALARM_RANGE;
    end else if ((spread_w << 1) > 32'(range_limit)) begin
      warn_chk = 1'b1;
    end
    if (alarm_chk == ALARM_NONE &&
        (mean_sat > offset_max || 18'(mean_sat) > win_hi)) begin
      alarm_chk = ALARM_ABOVE;
    end
    if (alarm_chk == ALARM_NONE &&
        (mean_sat < offset_min || 18'(mean_sat) < win_lo)) begin
      alarm_chk = ALARM_BELOW;
    end
  end

  // --------------------------------------------------------------------------
  // Final step: abort, down position and transition
  // --------------------------------------------------------------------------
  logic        out_free;
  logic        too_long_fin;
  logic        abort_fin;
  sazs_flags_t flags_fin;
  logic        set_lowered;
  logic [1:0]  trans_fin;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    too_long_fin = flags.too_long || item_alarm;
    abort_fin    = too_long_fin || (alarm_held != ALARM_NONE);
    flags_fin    = flags;
    if (abort_fin) begin
      flags_fin         = '0;
      flags_fin.failure = 1'b1;
    end
    set_lowered = !flags_fin.lowered && item_down;
    if (set_lowered) begin
      flags_fin.lowered       = 1'b1;
      flags_fin.timer_started = 1'b0;
    end
    if (flags_fin.failure) begin
      trans_fin = TRANS_FAILURE;
    end else if (flags_fin.fully_lowered && zero_done) begin
      trans_fin = TRANS_LOWERED;
    end else begin
      trans_fin = TRANS_NONE;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer, state and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_tvalid      <= 1'b0;
      average_count <= RST_AVERAGE_COUNT;
      range_limit   <= RST_RANGE_LIMIT;
      offset_max    <= RST_OFFSET_MAX;
      offset_min    <= RST_OFFSET_MIN;
      max_diff      <= RST_MAX_DIFF;
      last_offset   <= RST_LAST_OFFSET;
      lower_timeout <= RST_LOWER_TIMEOUT;
      settle_time   <= RST_SETTLE_TIME;
      start_delay   <= 2'd0;
      sample_count  <= 8'd0;
      sample_total  <= '0;
      sample_min    <= '0;
      sample_max    <= '0;
      zero_done     <= 1'b0;
      alarm_held    <= ALARM_NONE;
      flags         <= '0;
      timeout_count <= 16'd0;
      settle_count  <= 16'd0;
      item_enter    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_AVERAGE_COUNT: average_count <= cfg_data[7:0];
          REG_RANGE_LIMIT:   range_limit   <= cfg_data;
          REG_OFFSET_MAX:    offset_max    <= $signed(cfg_data);
          REG_OFFSET_MIN:    offset_min    <= $signed(cfg_data);
          REG_MAX_DIFF:      max_diff      <= cfg_data;
          REG_LAST_OFFSET:   last_offset   <= $signed(cfg_data);
          REG_LOWER_TIMEOUT: lower_timeout <= cfg_data;
          REG_SETTLE_TIME:   settle_time   <= cfg_data;
          default: ;
        endcase
      end

      // In the last step the output valid is set below whenever it is free.
      if (m_tvalid && m_tready && state != ST_FIN) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            item_down  <= s_tdata[16];
            item_alarm <= s_tdata[17];
            res_cmd    <= 1'b0;
            res_warn   <= 1'b0;
            res_valid  <= 1'b0;
            res_zoff   <= '0;
            res_zrnd   <= '0;
            state      <= ST_FIN;
            if (s_tuser[0] == KIND_ENTER) begin
              // Enter word: restart the delay and forget the last zero
              item_enter  <= 1'b1;
              start_delay <= 2'(START_DELAY);
              zero_done   <= 1'b0;
            end else begin
              item_enter    <= 1'b0;
              flags         <= flags_acc;
              timeout_count <= timeout_acc;
              settle_count  <= settle_acc;
              start_delay   <= delay_acc;
              res_cmd       <= lower_cmd;
              if (take_sample) begin
                sample_count <= count_acc;
                sample_total <= sample_total + TOTW'(sample_in);
                if (sample_count == 8'd0) begin
                  sample_min <= sample_in;
                  sample_max <= sample_in;
                end else if (sample_in < sample_min) begin
                  sample_min <= sample_in;
                end else if (sample_in > sample_max) begin
                  sample_max <= sample_in;
                end
                if (count_acc == average_count) begin
                  state <= ST_PREP;
                end
              end
            end
          end
        end

        ST_PREP: begin
          // Rounded mean: (2*|sum| + n) / (2*n), sign applied afterwards
          div_num   <= {total_mag, 1'b0} + NUMW'(sample_count);
          div_rem   <= 9'd0;
          div_cnt   <= CNTW'(NUMW);
          total_neg <= sample_total[TOTW-1];
          state     <= ST_DIV;
        end

        ST_DIV: begin
          div_rem <= div_rem_next;
          div_num <= {div_num[NUMW-2:0], div_ge};
          div_cnt <= div_cnt - CNTW'(1);
          if (div_cnt == CNTW'(1)) begin
            state <= ST_CHECK;
          end
        end

        ST_CHECK: begin
          res_zoff   <= mean_sat;
          res_zrnd   <= mean_rnd;
          res_warn   <= warn_chk;
          alarm_held <= alarm_chk;
          if (alarm_chk == ALARM_NONE) begin
            zero_done <= 1'b1;
            res_valid <= 1'b1;
          end
          state <= ST_FIN;
        end

        ST_FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
            if (item_enter) begin
              out_trans <= TRANS_NONE;
              out_alarm <= ALARM_NONE;
              out_lfail <= 1'b0;
              out_warn  <= 1'b0;
              out_valid <= 1'b0;
              out_zoff  <= 16'd0;
              out_zrnd  <= 12'd0;
              out_cmd   <= 1'b0;
            end else begin
              flags     <= flags_fin;
              out_trans <= trans_fin;
              out_alarm <= abort_fin ? alarm_held : ALARM_NONE;
              out_lfail <= abort_fin && too_long_fin;
              out_warn  <= res_warn;
              out_valid <= res_valid;
              out_zoff  <= res_zoff;
              out_zrnd  <= res_zrnd;
              out_cmd   <= res_cmd;
              if (abort_fin) begin
                sample_count <= 8'd0;
                sample_total <= '0;
                alarm_held   <= ALARM_NONE;
              end
              if (set_lowered) begin
                timeout_count <= 16'd0;
                settle_count  <= load_len(settle_time);
              end
            end
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- verif/sensor_auto_zero_supervisor_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensor auto-zero supervisor testbench
// Streams control-cycle words into the supervisor and predicts every result
// word with an independent cycle model. Results are compared field by field
// in arrival order. Both stream sides idle at random, and the receiver twice
// holds off long enough to back the block up. Register settings change
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module sensor_auto_zero_supervisor_tb;
  import sazs_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int QUIET_CYCLES = 40;
  localparam int LONG_HOLD    = 500;
  localparam int HOLD_AT_A    = 250;
  localparam int HOLD_AT_B    = 1000;
  localparam int NUM_PHASES   = 8;

  typedef struct {
    logic               kind;
    logic signed [15:0] sample;
    logic               down;
    logic               alarm;
  } cycle_word_t;

  typedef struct {
    logic [1:0]         transition;
    logic [1:0]         zero_alarm;
    logic               lower_failed;
    logic               range_warning;
    logic               zero_valid;
    logic signed [15:0] zero_offset;
    logic signed [11:0] zero_rounded;
    logic               lower_command;
  } zero_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  sensor_auto_zero_supervisor u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Register copies held by the predictor
  logic [7:0]         cf_avg;
  logic [15:0]        cf_range;
  logic signed [15:0] cf_omax;
  logic signed [15:0] cf_omin;
  logic [15:0]        cf_diff;
  logic signed [15:0] cf_last;
  logic [15:0]        cf_tmo;
  logic [15:0]        cf_settle;

  // Supervisor state as predicted
  logic [1:0]         az_delay;
  logic [7:0]         az_taken;
  logic signed [23:0] az_sum;
  logic signed [15:0] az_lo;
  logic signed [15:0] az_hi;
  logic signed [15:0] az_offset;
  logic               az_zeroed;
  logic [1:0]         az_alarm;
  sazs_flags_t        az_flags;
  logic [15:0]        az_tmo;
  logic [15:0]        az_settle;

  cycle_word_t  pending_words[$];
  zero_result_t expected_words[$];
  int errors = 0;

  function automatic void reset_supervisor_model();
    cf_avg    = RST_AVERAGE_COUNT;
    cf_range  = RST_RANGE_LIMIT;
    cf_omax   = RST_OFFSET_MAX;
    cf_omin   = RST_OFFSET_MIN;
    cf_diff   = RST_MAX_DIFF;
    cf_last   = RST_LAST_OFFSET;
    cf_tmo    = RST_LOWER_TIMEOUT;
    cf_settle = RST_SETTLE_TIME;
    az_delay  = '0;
    az_taken  = '0;
    az_sum    = '0;
    az_lo     = '0;
    az_hi     = '0;
    az_offset = '0;
    az_zeroed = 1'b0;
    az_alarm  = ALARM_NONE;
    az_flags  = '0;
    az_tmo    = '0;
    az_settle = '0;
  endfunction

  // One control cycle of the supervisor; updates the predicted state.
  function automatic zero_result_t next_supervisor_result(input cycle_word_t w);
    zero_result_t r;
    longint mag, quot, mean, spread, whole;
    r = '{default: '0};
    if (w.kind == KIND_ENTER) begin
      az_delay  = 2'(SAZS_START_DELAY);
      az_zeroed = 1'b0;
      return r;
    end

    if (az_tmo != 0) begin
      az_tmo--;
      if (az_tmo == 0) az_flags.too_long = 1'b1;
    end
    if (az_settle != 0) begin
      az_settle--;
      if (az_settle == 0) az_flags.fully_lowered = 1'b1;
    end

    if (az_alarm == ALARM_NONE && !az_flags.failure) begin
      r.lower_command = 1'b1;
      if (!az_flags.timer_started) begin
        az_tmo = (cf_tmo == 0) ? 16'd1 : cf_tmo;
        az_flags.timer_started = 1'b1;
      end
    end

    if (az_delay > 0) az_delay--;
    if (az_delay == 0 && az_taken < cf_avg) begin
      az_taken++;
      az_sum += w.sample;
      if (az_taken == 1) begin
        az_lo = w.sample;
        az_hi = w.sample;
      end else if (w.sample < az_lo) begin
        az_lo = w.sample;
      end else if (w.sample > az_hi) begin
        az_hi = w.sample;
      end
      if (az_taken >= cf_avg) begin
        // Mean rounded to nearest, ties away from zero.
        mag  = (az_sum < 0) ? -longint'(az_sum) : longint'(az_sum);
        quot = (2 * mag + longint'(az_taken)) / (2 * longint'(az_taken));
        mean = (az_sum < 0) ? -quot : quot;
        if (mean > 32767) mean = 32767;
        if (mean < -32768) mean = -32768;
        spread = longint'(az_hi) - longint'(az_lo);
        r.zero_offset = mean[15:0];
        whole = (((mean < 0) ? -mean : mean) + 8) >>> 4;
        if (mean < 0) whole = -whole;
        if (whole > 2047) whole = 2047;
        r.zero_rounded = whole[11:0];

        if (spread > longint'(cf_range)) az_alarm = ALARM_RANGE;
        else if (2 * spread > longint'(cf_range)) r.range_warning = 1'b1;
        if (az_alarm == ALARM_NONE && (mean > longint'(cf_omax) ||
            mean > longint'(cf_last) + longint'(cf_diff)))
          az_alarm = ALARM_ABOVE;
        if (az_alarm == ALARM_NONE && (mean < longint'(cf_omin) ||
            mean < longint'(cf_last) - longint'(cf_diff)))
          az_alarm = ALARM_BELOW;
        if (az_alarm == ALARM_NONE) begin
          az_offset    = r.zero_offset;
          az_zeroed    = 1'b1;
          r.zero_valid = 1'b1;
        end
      end
    end

    if (w.alarm) az_flags.too_long = 1'b1;

    // Failure is sticky: everything else is dropped, timers keep running.
    if (az_flags.too_long || az_alarm != ALARM_NONE) begin
      r.zero_alarm   = az_alarm;
      r.lower_failed = az_flags.too_long;
      az_flags         = '0;
      az_flags.failure = 1'b1;
      az_taken = '0;
      az_sum   = '0;
      az_alarm = ALARM_NONE;
    end

    if (!az_flags.lowered && w.down) begin
      az_flags.lowered       = 1'b1;
      az_flags.timer_started = 1'b0;
      az_tmo    = '0;
      az_settle = (cf_settle == 0) ? 16'd1 : cf_settle;
    end

    if (az_flags.failure) r.transition = TRANS_FAILURE;
    else if (az_flags.fully_lowered && az_zeroed) r.transition = TRANS_LOWERED;
    else r.transition = TRANS_NONE;
    return r;
  endfunction

  function automatic int draw_idle(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic int field_mismatch(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Sender
  cycle_word_t tx_word;
  int tx_wait = 0;
  int tx_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_words.push_back(next_supervisor_result(tx_word));
        tx_wait = draw_idle(tx_calm);
      end
      if (!s_tvalid || s_tready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          s_tvalid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          tx_word = pending_words.pop_front();
          s_tdata  <= {6'd0, tx_word.alarm, tx_word.down, tx_word.sample};
          s_tuser  <= tx_word.kind;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker
  zero_result_t rx_want;
  int rx_wait = 0;
  int rx_calm = 0;
  int rx_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        rx_count++;
        if (expected_words.size() == 0) begin
          $error("result word %h arrived with nothing expected", m_tdata);
          errors++;
        end else begin
          rx_want = expected_words.pop_front();
          errors += field_mismatch("transition", int'(rx_want.transition),
                                   int'(m_tdata[1:0]));
          errors += field_mismatch("zero_alarm", int'(rx_want.zero_alarm),
                                   int'(m_tdata[3:2]));
          errors += field_mismatch("lower_failed", int'(rx_want.lower_failed),
                                   int'(m_tdata[4]));
          errors += field_mismatch("range_warning", int'(rx_want.range_warning),
                                   int'(m_tdata[5]));
          errors += field_mismatch("zero_valid", int'(rx_want.zero_valid),
                                   int'(m_tdata[6]));
          errors += field_mismatch("zero_offset", int'(rx_want.zero_offset),
                                   int'($signed(m_tdata[22:7])));
          errors += field_mismatch("zero_rounded", int'(rx_want.zero_rounded),
                                   int'($signed(m_tdata[34:23])));
          errors += field_mismatch("lower_command", int'(rx_want.lower_command),
                                   int'(m_tdata[35]));
        end
        rx_wait = draw_idle(rx_calm);
        // A long hold-off lets the block fill up and stall its input.
        if (rx_count == HOLD_AT_A || rx_count == HOLD_AT_B) rx_wait = LONG_HOLD;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Stimulus
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_AVERAGE_COUNT: cf_avg    = val[7:0];
      REG_RANGE_LIMIT:   cf_range  = val;
      REG_OFFSET_MAX:    cf_omax   = val;
      REG_OFFSET_MIN:    cf_omin   = val;
      REG_MAX_DIFF:      cf_diff   = val;
      REG_LAST_OFFSET:   cf_last   = val;
      REG_LOWER_TIMEOUT: cf_tmo    = val;
      REG_SETTLE_TIME:   cf_settle = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_word(input logic kind, input int sample, input logic down,
                           input logic alarm);
    cycle_word_t w;
    w.kind   = kind;
    w.sample = 16'(sample);
    w.down   = down;
    w.alarm  = alarm;
    pending_words.push_back(w);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || s_tvalid || expected_words.size() != 0);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic set_phase_config(input int ph);
    case (ph)
      0: begin
        write_reg(REG_AVERAGE_COUNT, 16'd1);
        write_reg(REG_RANGE_LIMIT, 16'd0);
        write_reg(REG_OFFSET_MAX, 16'h7fff);
        write_reg(REG_OFFSET_MIN, 16'h8000);
        write_reg(REG_MAX_DIFF, 16'hffff);
        write_reg(REG_LAST_OFFSET, 16'd0);
        write_reg(REG_LOWER_TIMEOUT, 16'd0);
        write_reg(REG_SETTLE_TIME, 16'hffff);
      end
      1: begin
        // Bounds inverted on purpose, so every completed set raises an alarm.
        write_reg(REG_AVERAGE_COUNT, 16'd255);
        write_reg(REG_RANGE_LIMIT, 16'hffff);
        write_reg(REG_OFFSET_MAX, 16'h8000);
        write_reg(REG_OFFSET_MIN, 16'h7fff);
        write_reg(REG_MAX_DIFF, 16'd0);
        write_reg(REG_LAST_OFFSET, 16'h8000);
        write_reg(REG_LOWER_TIMEOUT, 16'hffff);
        write_reg(REG_SETTLE_TIME, 16'd1);
      end
      2: begin
        write_reg(REG_AVERAGE_COUNT, 16'd0);
        write_reg(REG_LAST_OFFSET, 16'h7fff);
      end
      default: begin
        write_reg(REG_AVERAGE_COUNT, 16'($urandom_range(1, 12)));
        write_reg(REG_RANGE_LIMIT, 16'($urandom_range(0, 80)));
        write_reg(REG_OFFSET_MAX, 16'($urandom_range(0, 500)));
        write_reg(REG_OFFSET_MIN, 16'(-int'($urandom_range(0, 500))));
        write_reg(REG_MAX_DIFF, 16'($urandom_range(0, 400)));
        write_reg(REG_LAST_OFFSET, 16'(int'($urandom_range(0, 400)) - 200));
        write_reg(REG_LOWER_TIMEOUT, 16'($urandom_range(1, 40)));
        write_reg(REG_SETTLE_TIME, 16'($urandom_range(0, 30)));
      end
    endcase
  endtask

  // Mostly enter words followed by runs of samples clustered round a centre;
  // the rest is random noise and runs with the enter word left out.
  task automatic fill_phase(input int target);
    int count, len, centre, spread, sample, down_at, i;
    logic long_set;
    count = 0;
    while (count < target) begin
      if ($urandom_range(0, 3) == 0) begin
        len = $urandom_range(1, 10);
        for (i = 0; i < len; i++)
          push_word(1'($urandom_range(0, 1)), $urandom_range(0, 65535),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        count += len;
      end else begin
        long_set = (cf_avg > 30);
        len = long_set ? int'(cf_avg) + $urandom_range(2, 12)
                       : $urandom_range(3, 3 * int'(cf_avg) + 8);
        case ($urandom_range(0, 3))
          0: centre = int'(cf_last);
          1: centre = int'(cf_omax);
          2: centre = int'(cf_omin);
          default: centre = int'($urandom_range(0, 65535)) - 32768;
        endcase
        spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(0, 2 * int'(cf_range) + 4);
        down_at = $urandom_range(0, len);
        if ($urandom_range(0, 7) != 0) begin
          push_word(KIND_ENTER, $urandom_range(0, 65535), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
          count++;
        end
        for (i = 0; i < len; i++) begin
          sample = centre + int'($urandom_range(0, spread)) - spread / 2;
          if (sample > 32767) sample = 32767;
          if (sample < -32768) sample = -32768;
          push_word(KIND_CYCLE, sample,
                    (i >= down_at) && ($urandom_range(0, 7) != 0),
                    !long_set && ($urandom_range(0, 59) == 0));
        end
        count += len;
      end
    end
  endtask

  initial begin
    int ph;
    reset_supervisor_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Clean lowering and zero with a tie in the mean, then an alarm abort.
    write_reg(REG_AVERAGE_COUNT, 16'd4);
    write_reg(REG_SETTLE_TIME, 16'd0);
    push_word(KIND_ENTER, 32767, 1'b1, 1'b1);
    push_word(KIND_CYCLE, 5, 1'b0, 1'b0);
    push_word(KIND_CYCLE, -3, 1'b1, 1'b0);
    push_word(KIND_CYCLE, 7, 1'b0, 1'b0);
    push_word(KIND_CYCLE, 0, 1'b0, 1'b0);
    push_word(KIND_CYCLE, 2, 1'b0, 1'b0);
    push_word(KIND_CYCLE, 1, 1'b0, 1'b0);
    push_word(KIND_ENTER, -32768, 1'b0, 1'b0);
    push_word(KIND_CYCLE, 0, 1'b1, 1'b0);
    push_word(KIND_CYCLE, -32768, 1'b0, 1'b1);
    wait_idle();

    // After the failure: range, above and below alarms, saturated rounding,
    // a negative tie and a range warning, in sets of two.
    write_reg(REG_AVERAGE_COUNT, 16'd2);
    push_word(KIND_CYCLE, 32767, 1'b0, 1'b0);
    push_word(KIND_CYCLE, -32768, 1'b0, 1'b0);
    push_word(KIND_CYCLE, 32767, 1'b0, 1'b0);
    push_word(KIND_CYCLE, 32767, 1'b0, 1'b0);
    push_word(KIND_CYCLE, -32768, 1'b0, 1'b0);
    push_word(KIND_CYCLE, -32768, 1'b0, 1'b0);
    push_word(KIND_CYCLE, -7, 1'b0, 1'b0);
    push_word(KIND_CYCLE, -8, 1'b0, 1'b0);
    push_word(KIND_CYCLE, 0, 1'b0, 1'b0);
    push_word(KIND_CYCLE, 20, 1'b0, 1'b0);
    push_word(KIND_ENTER, 0, 1'b1, 1'b0);
    push_word(KIND_CYCLE, 5, 1'b1, 1'b0);
    wait_idle();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      set_phase_config(ph);
      fill_phase((ph == 1) ? 320 : (ph == 2) ? 60 : 140);
      wait_idle();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule
